[rtl/core/rrt_pkg.sv]
// package for the rssi ranging and trilateration unit: widths, tables, types
package rrt_pkg;

	localparam int DIST_BITS = 16;
	localparam int OUT_W     = 16;
	localparam int XOUT_W    = OUT_W + 1;
	localparam int BASE_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int POWER_W   = 12;
	localparam int EXPO_W    = 12;
	localparam int RM_W      = 12;
	localparam int RS_W      = 8;
	localparam int DIFF_W    = 13;

	// exponent divider
	localparam int EXP_NUM_W = 24;
	localparam int EXP_DEN_W = 15;
	localparam int EXP_QW    = 12;

	// mantissa and scaling
	localparam int M_W     = 28;
	localparam int K_W     = 26;
	localparam int MP_W    = M_W + K_W;
	localparam int SCALE_W = 30;
	localparam int PROD_W  = 59;
	localparam int T_W     = PROD_W - 24;
	localparam int POW_W   = 27;
	localparam int PT_W    = 26;
	localparam int POW_QW  = 10;

	localparam int RANGE_LAT = 1 + EXP_QW + 1 + 8 + 1 + 1 + POW_QW + 1;

	// geometry
	localparam int GW        = (DIST_BITS > BASE_W) ? DIST_BITS : BASE_W;
	localparam int SQ_W      = 2 * GW;
	localparam int GQ_W      = GW + 1;
	localparam int GNUM_W    = 2 * GW + 2;
	localparam int GEO_LAT   = 8 + GQ_W + GW;
	localparam int TOTAL_LAT = RANGE_LAT + GEO_LAT;

	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	localparam logic [POWER_W-1:0] POWER_RST    = 12'hB60;
	localparam logic [EXPO_W-1:0]  EXPONENT_RST = 12'd768;
	localparam logic [BASE_W-1:0]  BASELINE_RST = 16'd2000;

	localparam logic [K_W-1:0] ROOT_STEP [8] = '{
		26'd16928799, 26'd17081751, 26'd17391815, 26'd18028928,
		26'd19374027, 26'd22372777, 26'd29834578, 26'd53054215
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POWER    = 2'd0,
		REG_EXPONENT = 2'd1,
		REG_BASELINE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [GW-1:0] d1;
		logic [GW-1:0] d2;
		logic          online;
		logic          sat;
	} geo_com_t;

	// 10^(8-hi) for negative decades, 1 otherwise
	function automatic logic [POW_W-1:0] pow10_of(input logic [3:0] hi);
		logic [POW_W-1:0] v;
		case (hi)
			4'd0:    v = 27'd100000000;
			4'd1:    v = 27'd10000000;
			4'd2:    v = 27'd1000000;
			4'd3:    v = 27'd100000;
			4'd4:    v = 27'd10000;
			4'd5:    v = 27'd1000;
			4'd6:    v = 27'd100;
			4'd7:    v = 27'd10;
			default: v = 27'd1;
		endcase
		return v;
	endfunction

	// 1000 * 10^(hi-8) for decades 0 to 6 (hi 8 to 14), 1000 otherwise
	function automatic logic [SCALE_W-1:0] scale_of(input logic [3:0] hi);
		logic [SCALE_W-1:0] v;
		case (hi)
			4'd9:    v = 30'd10000;
			4'd10:   v = 30'd100000;
			4'd11:   v = 30'd1000000;
			4'd12:   v = 30'd10000000;
			4'd13:   v = 30'd100000000;
			4'd14:   v = 30'd1000000000;
			default: v = 30'd1000;
		endcase
		return v;
	endfunction

endpackage

[rtl/core/rrt_ifs.sv]
// channel interfaces of the rssi ranging and trilateration unit
interface rrt_sample_if;
	logic                              valid;
	logic                              ready;
	logic signed [rrt_pkg::RM_W-1:0]   rssi_master;
	logic signed [rrt_pkg::RS_W-1:0]   rssi_slave;
	modport source (output valid, rssi_master, rssi_slave, input ready);
	modport sink (input valid, rssi_master, rssi_slave, output ready);
endinterface

interface rrt_result_if;
	logic                               valid;
	logic                               ready;
	logic [rrt_pkg::OUT_W-1:0]          range_master_mm;
	logic [rrt_pkg::OUT_W-1:0]          range_slave_mm;
	logic signed [rrt_pkg::XOUT_W-1:0]  pos_x_mm;
	logic [rrt_pkg::OUT_W-1:0]          pos_y_mm;
	logic                               on_baseline;
	logic                               saturated;
	modport source (output valid, range_master_mm, range_slave_mm, pos_x_mm, pos_y_mm,
		on_baseline, saturated, input ready);
	modport sink (input valid, range_master_mm, range_slave_mm, pos_x_mm, pos_y_mm,
		on_baseline, saturated, output ready);
endinterface

interface rrt_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rrt_pkg::CFG_IDX_W-1:0]     index;
	logic [rrt_pkg::CFG_W-1:0]         data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/rssi_ranging_trilateration_unit.sv]
// top level of the rssi ranging and two-anchor trilateration unit
//
// sample channel: one transfer carries the master rssi (dBm q8.4) and the
// slave rssi (whole dBm). each is turned into a range in millimetres and the
// target position is solved against a baseline between the two anchors.
// result channel: one transfer per sample with both ranges, x and y in mm,
// an on-baseline flag and a saturation flag.
// cfg channel: writes power at one metre, path loss exponent and baseline;
// ready is always high, write only while no sample is in flight.
// each sample passes through one range converter per rssi (exponent
// divider, eight mantissa multiplies, decade divider) and then through
// the geometry (x divider, square root).
// a new sample is taken every cycle unless the receiver stalls; throughput is one result per cycle.
// reset clears the pipeline valid bits and loads the default registers.
// when the receiver stalls, the whole pipeline holds and sample ready drops.
module rssi_ranging_trilateration_unit (
	input  logic         clk,
	input  logic         arst_n,
	rrt_sample_if.sink   sample,
	rrt_result_if.source result,
	rrt_cfg_if.sink      cfg
);
	import rrt_pkg::*;

	logic signed [POWER_W-1:0] power_q;
	logic [EXPO_W-1:0]         exponent_q;
	logic [BASE_W-1:0]         baseline_q;

	logic [TOTAL_LAT-1:0] vld_q;
	logic                 en;
	logic                 accept;

	logic signed [RM_W-1:0]   rs16;
	logic signed [DIFF_W-1:0] diff_m;
	logic signed [DIFF_W-1:0] diff_s;

	logic [DIST_BITS-1:0] rng_m;
	logic [DIST_BITS-1:0] rng_s;
	logic                 sat_m;
	logic                 sat_s;

	// geometry stages
	logic [GW-1:0]   base;
	logic [GW-1:0]   d1w;
	logic [GW-1:0]   d2w;

	geo_com_t        c_g1;
	logic [SQ_W-1:0] sq1_g1;
	logic [SQ_W-1:0] sq2_g1;
	logic [SQ_W-1:0] sqd_g1;
	logic [GW-1:0]   base_g1;

	geo_com_t         c_g2;
	logic [SQ_W:0]    a_g2;
	logic [SQ_W-1:0]  b_g2;
	logic [SQ_W-1:0]  sq1_g2;
	logic [GW-1:0]    base_g2;

	geo_com_t         c_g3;
	logic [SQ_W:0]    mag_g3;
	logic             pos_g3;
	logic [SQ_W-1:0]  sq1_g3;
	logic [GW-1:0]    base_g3;

	geo_com_t          gc_s   [GQ_W+1];
	logic [GNUM_W-1:0] grem_s [GQ_W+1];
	logic [GQ_W-1:0]   gden_s [GQ_W+1];
	logic [GQ_W-1:0]   gq_s   [GQ_W+1];
	logic              gpos_s [GQ_W+1];
	logic [SQ_W-1:0]   gsq1_s [GQ_W+1];

	logic [GNUM_W-1:0] gtrial [GQ_W];
	logic              gge    [GQ_W];
	logic [GNUM_W-1:0] grem_n [GQ_W];

	geo_com_t        c_g5;
	logic [GQ_W-1:0] qx_g5;
	logic            ge_g5;
	logic            pos_g5;
	logic [SQ_W-1:0] qsq_g5;
	logic [SQ_W-1:0] sq1_g5;

	geo_com_t        sc_s   [GW+1];
	logic [SQ_W-1:0] srem_s [GW+1];
	logic [SQ_W-1:0] sr_s   [GW+1];
	logic [GQ_W-1:0] sqx_s  [GW+1];
	logic            sge_s  [GW+1];
	logic            spos_s [GW+1];

	logic [SQ_W-1:0] sbit   [GW];
	logic [SQ_W:0]   ssum   [GW];
	logic            stk    [GW];
	logic [SQ_W-1:0] srem_n [GW];
	logic [SQ_W-1:0] sr_n   [GW];

	geo_com_t        c_g7;
	logic [GW:0]     yr_g7;
	logic [GQ_W-1:0] qx_g7;
	logic            ge_g7;
	logic            pos_g7;

	// output stage
	logic [GQ_W-1:0]       xmag;
	logic                  xneg;
	logic [GW:0]           ymag;
	logic [OUT_W-1:0]      xclip;
	logic [OUT_W-1:0]      yclip;
	logic [OUT_W-1:0]      d1clip;
	logic [OUT_W-1:0]      d2clip;
	logic                  osat;
	logic [XOUT_W-1:0]     xext;

	logic [OUT_W-1:0]         range_master_q;
	logic [OUT_W-1:0]         range_slave_q;
	logic signed [XOUT_W-1:0] pos_x_q;
	logic [OUT_W-1:0]         pos_y_q;
	logic                     on_baseline_q;
	logic                     saturated_q;

	assign en           = !vld_q[TOTAL_LAT-1] || result.ready;
	assign accept       = sample.valid && en;
	assign sample.ready = en;
	assign cfg.ready    = 1'b1;

	assign result.valid           = vld_q[TOTAL_LAT-1];
	assign result.range_master_mm = range_master_q;
	assign result.range_slave_mm  = range_slave_q;
	assign result.pos_x_mm        = pos_x_q;
	assign result.pos_y_mm        = pos_y_q;
	assign result.on_baseline     = on_baseline_q;
	assign result.saturated       = saturated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q    <= POWER_RST;
			exponent_q <= EXPONENT_RST;
			baseline_q <= BASELINE_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_POWER:    power_q    <= cfg.data[POWER_W-1:0];
				REG_EXPONENT: exponent_q <= cfg.data[EXPO_W-1:0];
				REG_BASELINE: baseline_q <= cfg.data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], accept};
		end
	end

	always_comb begin
		rs16   = {sample.rssi_slave, 4'b0000};
		diff_m = DIFF_W'(power_q) - DIFF_W'(sample.rssi_master);
		diff_s = DIFF_W'(power_q) - DIFF_W'(rs16);
	end

	rrt_range u_range_master (
		.clk      (clk),
		.en       (en),
		.diff     (diff_m),
		.is_zero  (sample.rssi_master == '0),
		.exponent (exponent_q),
		.range_mm (rng_m),
		.sat      (sat_m)
	);

	rrt_range u_range_slave (
		.clk      (clk),
		.en       (en),
		.diff     (diff_s),
		.is_zero  (sample.rssi_slave == '0),
		.exponent (exponent_q),
		.range_mm (rng_s),
		.sat      (sat_s)
	);

	always_comb begin
		base = (baseline_q == '0) ? GW'(1) : GW'(baseline_q);
		d1w  = GW'(rng_m);
		d2w  = GW'(rng_s);
	end

	always_comb begin
		for (int k = 0; k < GQ_W; k++) begin
			gtrial[k] = GNUM_W'(gden_s[k]) << (GQ_W - 1 - k);
			gge[k]    = grem_s[k] >= gtrial[k];
			grem_n[k] = gge[k] ? (grem_s[k] - gtrial[k]) : grem_s[k];
		end
	end

	always_comb begin
		for (int k = 0; k < GW; k++) begin
			sbit[k]   = SQ_W'(1) << (2 * (GW - 1 - k));
			ssum[k]   = (SQ_W+1)'(sr_s[k]) + (SQ_W+1)'(sbit[k]);
			stk[k]    = (SQ_W+1)'(srem_s[k]) >= ssum[k];
			srem_n[k] = stk[k] ? SQ_W'((SQ_W+1)'(srem_s[k]) - ssum[k]) : srem_s[k];
			sr_n[k]   = stk[k] ? ((sr_s[k] >> 1) + sbit[k]) : (sr_s[k] >> 1);
		end
	end

	always_comb begin
		if (c_g7.online) begin
			xmag = GQ_W'(c_g7.d1);
			xneg = 1'b0;
			ymag = '0;
		end else begin
			xmag = qx_g7;
			xneg = !pos_g7;
			ymag = ge_g7 ? '0 : yr_g7;
		end
		osat   = c_g7.sat;
		xclip  = xmag[OUT_W-1:0];
		yclip  = ymag[OUT_W-1:0];
		d1clip = c_g7.d1[OUT_W-1:0];
		d2clip = c_g7.d2[OUT_W-1:0];
		if (xmag > GQ_W'(OUT_MAX)) begin
			xclip = OUT_MAX;
			osat  = 1'b1;
		end
		if (ymag > (GW+1)'(OUT_MAX)) begin
			yclip = OUT_MAX;
			osat  = 1'b1;
		end
		if (c_g7.d1 > GW'(OUT_MAX)) begin
			d1clip = OUT_MAX;
			osat   = 1'b1;
		end
		if (c_g7.d2 > GW'(OUT_MAX)) begin
			d2clip = OUT_MAX;
			osat   = 1'b1;
		end
		xext = {1'b0, xclip};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_g1.d1     <= d1w;
			c_g1.d2     <= d2w;
			c_g1.online <= ((GW+1)'(d1w) + (GW+1)'(d2w)) <= (GW+1)'(base);
			c_g1.sat    <= sat_m || sat_s;
			sq1_g1      <= SQ_W'(d1w) * SQ_W'(d1w);
			sq2_g1      <= SQ_W'(d2w) * SQ_W'(d2w);
			sqd_g1      <= SQ_W'(base) * SQ_W'(base);
			base_g1     <= base;

			c_g2    <= c_g1;
			a_g2    <= (SQ_W+1)'(sq1_g1) + (SQ_W+1)'(sqd_g1);
			b_g2    <= sq2_g1;
			sq1_g2  <= sq1_g1;
			base_g2 <= base_g1;

			c_g3    <= c_g2;
			pos_g3  <= a_g2 >= (SQ_W+1)'(b_g2);
			mag_g3  <= (a_g2 >= (SQ_W+1)'(b_g2)) ? (a_g2 - (SQ_W+1)'(b_g2))
				: ((SQ_W+1)'(b_g2) - a_g2);
			sq1_g3  <= sq1_g2;
			base_g3 <= base_g2;

			gc_s[0]   <= c_g3;
			grem_s[0] <= GNUM_W'(mag_g3) + GNUM_W'(base_g3);
			gden_s[0] <= {base_g3, 1'b0};
			gq_s[0]   <= '0;
			gpos_s[0] <= pos_g3;
			gsq1_s[0] <= sq1_g3;
			for (int k = 0; k < GQ_W; k++) begin
				gc_s[k+1]   <= gc_s[k];
				grem_s[k+1] <= grem_n[k];
				gden_s[k+1] <= gden_s[k];
				gq_s[k+1]   <= {gq_s[k][GQ_W-2:0], gge[k]};
				gpos_s[k+1] <= gpos_s[k];
				gsq1_s[k+1] <= gsq1_s[k];
			end

			c_g5   <= gc_s[GQ_W];
			qx_g5  <= gq_s[GQ_W];
			ge_g5  <= gq_s[GQ_W] >= GQ_W'(gc_s[GQ_W].d1);
			pos_g5 <= gpos_s[GQ_W];
			qsq_g5 <= SQ_W'(gq_s[GQ_W][GW-1:0]) * SQ_W'(gq_s[GQ_W][GW-1:0]);
			sq1_g5 <= gsq1_s[GQ_W];

			sc_s[0]   <= c_g5;
			srem_s[0] <= ge_g5 ? '0 : (sq1_g5 - qsq_g5);
			sr_s[0]   <= '0;
			sqx_s[0]  <= qx_g5;
			sge_s[0]  <= ge_g5;
			spos_s[0] <= pos_g5;
			for (int k = 0; k < GW; k++) begin
				sc_s[k+1]   <= sc_s[k];
				srem_s[k+1] <= srem_n[k];
				sr_s[k+1]   <= sr_n[k];
				sqx_s[k+1]  <= sqx_s[k];
				sge_s[k+1]  <= sge_s[k];
				spos_s[k+1] <= spos_s[k];
			end

			c_g7   <= sc_s[GW];
			yr_g7  <= (GW+1)'(sr_s[GW][GW-1:0]) + (GW+1)'(srem_s[GW] > sr_s[GW]);
			qx_g7  <= sqx_s[GW];
			ge_g7  <= sge_s[GW];
			pos_g7 <= spos_s[GW];

			range_master_q <= d1clip;
			range_slave_q  <= d2clip;
			pos_x_q        <= xneg ? -xext : xext;
			pos_y_q        <= yclip;
			on_baseline_q  <= c_g7.online;
			saturated_q    <= osat;
		end
	end

endmodule

[rtl/core/rrt_range.sv]
// pipelined rssi to range conversion with the log-distance model
module rrt_range (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [rrt_pkg::DIFF_W-1:0]   diff,
	input  logic                                is_zero,
	input  logic [rrt_pkg::EXPO_W-1:0]          exponent,
	output logic [rrt_pkg::DIST_BITS-1:0]       range_mm,
	output logic                                sat
);
	import rrt_pkg::*;

	localparam int ETR_W = EXP_DEN_W + EXP_QW;
	localparam int PTR_W = POW_W + POW_QW;

	// exponent divider
	logic [DIFF_W-1:0]    mag;
	logic [EXPO_W-1:0]    n_eff;
	logic [EXP_DEN_W-1:0] den;
	logic [EXP_NUM_W-1:0] num;

	logic [EXP_NUM_W-1:0] erem_s  [EXP_QW+1];
	logic [EXP_DEN_W-1:0] eden_s  [EXP_QW+1];
	logic [EXP_QW-1:0]    eq_s    [EXP_QW+1];
	logic                 eneg_s  [EXP_QW+1];
	logic                 ezero_s [EXP_QW+1];

	logic [ETR_W-1:0]     etrial [EXP_QW];
	logic                 ege    [EXP_QW];
	logic [EXP_NUM_W-1:0] erem_n [EXP_QW];

	// decode and mantissa
	logic [EXP_QW-1:0] q;
	logic [EXP_QW-1:0] u;
	logic              dsat;

	logic [M_W-1:0] mnt_s   [9];
	logic [3:0]     mhi_s   [9];
	logic [7:0]     mf_s    [9];
	logic           msat_s  [9];
	logic           mzero_s [9];

	logic [MP_W-1:0] mprod [8];
	logic [MP_W-1:0] mrnd  [8];
	logic [M_W-1:0]  mnt_n [8];

	// scaling
	logic [PROD_W-1:0] prod_s;
	logic [3:0]        xhi_s;
	logic              xsat_s;
	logic              xzero_s;

	logic [PROD_W-1:0] sum;
	logic [T_W-1:0]    t;
	logic              tpos;
	logic              tsat;

	// decade divider
	logic [PT_W-1:0]      prem_s  [POW_QW+1];
	logic [POW_W-1:0]     pdvs_s  [POW_QW+1];
	logic [POW_QW-1:0]    pq_s    [POW_QW+1];
	logic                 ppos_s  [POW_QW+1];
	logic [DIST_BITS-1:0] prp_s   [POW_QW+1];
	logic                 psat_s  [POW_QW+1];
	logic                 pzero_s [POW_QW+1];

	logic [PTR_W-1:0] ptrial [POW_QW];
	logic             pge    [POW_QW];
	logic [PT_W-1:0]  prem_n [POW_QW];

	always_comb begin
		mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		n_eff = (exponent == '0) ? EXPO_W'(1) : exponent;
		den   = EXP_DEN_W'({n_eff, 2'b00}) + EXP_DEN_W'(n_eff);
		num   = {mag, 11'b0} + EXP_NUM_W'(den >> 1);
	end

	always_comb begin
		for (int k = 0; k < EXP_QW; k++) begin
			etrial[k] = ETR_W'(eden_s[k]) << (EXP_QW - 1 - k);
			ege[k]    = ETR_W'(erem_s[k]) >= etrial[k];
			erem_n[k] = ege[k] ? EXP_NUM_W'(ETR_W'(erem_s[k]) - etrial[k]) : erem_s[k];
		end
	end

	always_comb begin
		q    = eq_s[EXP_QW];
		dsat = 1'b0;
		if (!eneg_s[EXP_QW]) begin
			dsat = q[EXP_QW-1];
			u    = {1'b1, q[EXP_QW-2:0]};
		end else begin
			u = q[EXP_QW-1] ? '0 : (12'd2048 - q);
		end
		if (u[11:8] == 4'hF) begin
			dsat = 1'b1;
		end
	end

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			mprod[b] = MP_W'(mnt_s[b]) * MP_W'(ROOT_STEP[b]);
			mrnd[b]  = mprod[b] + (MP_W'(1) << 23);
			mnt_n[b] = mf_s[b][b] ? M_W'(mrnd[b] >> 24) : mnt_s[b];
		end
	end

	always_comb begin
		sum  = prod_s + (PROD_W'(pow10_of(xhi_s)) << 23);
		t    = sum[PROD_W-1:24];
		tpos = xhi_s[3];
		tsat = xsat_s || (tpos && (t > T_W'({DIST_BITS{1'b1}})));
	end

	always_comb begin
		for (int k = 0; k < POW_QW; k++) begin
			ptrial[k] = PTR_W'(pdvs_s[k]) << (POW_QW - 1 - k);
			pge[k]    = PTR_W'(prem_s[k]) >= ptrial[k];
			prem_n[k] = pge[k] ? PT_W'(PTR_W'(prem_s[k]) - ptrial[k]) : prem_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			erem_s[0]  <= num;
			eden_s[0]  <= den;
			eq_s[0]    <= '0;
			eneg_s[0]  <= diff[DIFF_W-1];
			ezero_s[0] <= is_zero;
			for (int k = 0; k < EXP_QW; k++) begin
				erem_s[k+1]  <= erem_n[k];
				eden_s[k+1]  <= eden_s[k];
				eq_s[k+1]    <= {eq_s[k][EXP_QW-2:0], ege[k]};
				eneg_s[k+1]  <= eneg_s[k];
				ezero_s[k+1] <= ezero_s[k];
			end

			mnt_s[0]   <= M_W'(1) << 24;
			mhi_s[0]   <= u[11:8];
			mf_s[0]    <= u[7:0];
			msat_s[0]  <= dsat;
			mzero_s[0] <= ezero_s[EXP_QW];
			for (int b = 0; b < 8; b++) begin
				mnt_s[b+1]   <= mnt_n[b];
				mhi_s[b+1]   <= mhi_s[b];
				mf_s[b+1]    <= mf_s[b];
				msat_s[b+1]  <= msat_s[b];
				mzero_s[b+1] <= mzero_s[b];
			end

			prod_s  <= PROD_W'(mnt_s[8]) * PROD_W'(scale_of(mhi_s[8]));
			xhi_s   <= mhi_s[8];
			xsat_s  <= msat_s[8];
			xzero_s <= mzero_s[8];

			prem_s[0]  <= t[PT_W-1:0];
			pdvs_s[0]  <= pow10_of(xhi_s);
			pq_s[0]    <= '0;
			ppos_s[0]  <= tpos;
			prp_s[0]   <= t[DIST_BITS-1:0];
			psat_s[0]  <= tsat;
			pzero_s[0] <= xzero_s;
			for (int k = 0; k < POW_QW; k++) begin
				prem_s[k+1]  <= prem_n[k];
				pdvs_s[k+1]  <= pdvs_s[k];
				pq_s[k+1]    <= {pq_s[k][POW_QW-2:0], pge[k]};
				ppos_s[k+1]  <= ppos_s[k];
				prp_s[k+1]   <= prp_s[k];
				psat_s[k+1]  <= psat_s[k];
				pzero_s[k+1] <= pzero_s[k];
			end

			if (pzero_s[POW_QW]) begin
				range_mm <= '0;
			end else if (psat_s[POW_QW]) begin
				range_mm <= '1;
			end else if (ppos_s[POW_QW]) begin
				range_mm <= prp_s[POW_QW];
			end else begin
				range_mm <= DIST_BITS'(pq_s[POW_QW]);
			end
			sat <= !pzero_s[POW_QW] && psat_s[POW_QW];
		end
	end

endmodule

[bench/rssi_ranging_trilateration_unit_tb.sv]
// testbench for the rssi ranging and trilateration unit: range and position scoreboard
`timescale 1ns / 1ps

module rssi_ranging_trilateration_unit_tb;
	import rrt_pkg::*;

	localparam int LATENCY = 76;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [63:0] RANGE_MAX = (64'd1 << DIST_BITS) - 1;

	typedef struct packed {
		logic [OUT_W-1:0]         d1;
		logic [OUT_W-1:0]         d2;
		logic signed [XOUT_W-1:0] x;
		logic [OUT_W-1:0]         y;
		logic                     online;
		logic                     sat;
	} position_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rrt_sample_if sample ();
	rrt_result_if result ();
	rrt_cfg_if    cfg ();

	rssi_ranging_trilateration_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [POWER_W-1:0] cur_power = POWER_RST;
	logic [EXPO_W-1:0]  cur_expo = EXPONENT_RST;
	logic [BASE_W-1:0]  cur_base = BASELINE_RST;

	localparam logic [63:0] ROOT_K [8] = '{
		64'd16928799, 64'd17081751, 64'd17391815, 64'd18028928,
		64'd19374027, 64'd22372777, 64'd29834578, 64'd53054215
	};

	function automatic logic [63:0] rssi_to_range(input longint diff, inout logic sat);
		longint num, e, mag, q, den, i;
		logic [63:0] m, v, r, dv, p10;
		logic [11:0] u;
		num = diff * 2048;
		den = 5 * ((cur_expo == 0) ? 1 : longint'(cur_expo));
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		e = (num < 0) ? -q : q;
		if (e > 2047) begin
			sat = 1'b1;
			return RANGE_MAX;
		end
		if (e < -2048)
			e = -2048;
		u = 12'(e + 2048);
		i = longint'(u[11:8]) - 8;
		if (i >= 7) begin
			sat = 1'b1;
			return RANGE_MAX;
		end
		m = 64'd1 << 24;
		for (int b = 0; b < 8; b++)
			if (u[b])
				m = (m * ROOT_K[b] + (64'd1 << 23)) >> 24;
		v = 1000 * m;
		p10 = 1;
		for (int k = 0; k < ((i < 0) ? -i : i); k++)
			p10 = p10 * 10;
		if (i >= 0) begin
			r = (v * p10 + (64'd1 << 23)) >> 24;
		end else begin
			dv = p10 << 24;
			r = (v + dv / 2) / dv;
		end
		if (r > RANGE_MAX) begin
			sat = 1'b1;
			r = RANGE_MAX;
		end
		return r;
	endfunction

	function automatic logic [63:0] nearest_root(input logic [63:0] val);
		logic [63:0] r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > val)
			bitv >>= 2;
		while (bitv != 0) begin
			if (val >= r + bitv) begin
				val -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		if (val > r)
			r++;
		return r;
	endfunction

	function automatic position_t locate_target(input logic signed [RM_W-1:0] rm,
		input logic signed [RS_W-1:0] rs);
		position_t o;
		logic sat;
		longint p;
		logic [63:0] d1, d2, dd, a, b, mag, qx, y;
		longint x;
		logic online;
		sat = 1'b0;
		p = longint'($signed(cur_power));
		d1 = (rm == 0) ? 64'd0 : rssi_to_range(p - longint'(rm), sat);
		d2 = (rs == 0) ? 64'd0 : rssi_to_range(p - longint'(rs) * 16, sat);
		dd = (cur_base == 0) ? 64'd1 : 64'(cur_base);
		online = (d1 + d2) <= dd;
		if (online) begin
			x = longint'(d1);
			y = 0;
		end else begin
			a = d1 * d1 + dd * dd;
			b = d2 * d2;
			mag = (a >= b) ? a - b : b - a;
			qx = (mag + dd) / (2 * dd);
			x = (a >= b) ? longint'(qx) : -longint'(qx);
			y = (qx >= d1) ? 64'd0 : nearest_root(d1 * d1 - qx * qx);
		end
		if (x > 65535) begin x = 65535; sat = 1'b1; end
		if (x < -65535) begin x = -65535; sat = 1'b1; end
		if (y > 65535) begin y = 65535; sat = 1'b1; end
		if (d1 > 65535) begin d1 = 65535; sat = 1'b1; end
		if (d2 > 65535) begin d2 = 65535; sat = 1'b1; end
		o.d1 = d1[15:0];
		o.d2 = d2[15:0];
		o.x = x[16:0];
		o.y = y[15:0];
		o.online = online;
		o.sat = sat;
		return o;
	endfunction

	class position_scoreboard;
		position_t pending[$];
		int mismatches;

		function void note_sample(position_t p);
			pending.push_back(p);
		endfunction

		function void check_result(position_t got);
			position_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p actual %p", want, got);
			end
		endfunction
	endclass

	position_scoreboard board = new();
	bit src_idle_on = 1'b1;
	bit snk_idle_on = 1'b1;
	int quiet_cycles = 0;

	always @(posedge clk) begin
		position_t got;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (sample.valid && sample.ready) begin
				board.note_sample(locate_target(sample.rssi_master, sample.rssi_slave));
				moved = 1'b1;
			end
			if (result.valid && result.ready) begin
				got.d1 = result.range_master_mm;
				got.d2 = result.range_slave_mm;
				got.x = result.pos_x_mm;
				got.y = result.pos_y_mm;
				got.online = result.on_baseline;
				got.sat = result.saturated;
				board.check_result(got);
				moved = 1'b1;
			end
			if (cfg.valid && cfg.ready)
				moved = 1'b1;
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		int n;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (snk_idle_on && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 16);
				result.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			result.ready <= 1'b1;
		end
	end

	task automatic write_register(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg.index <= idx;
		cfg.data <= val;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			REG_POWER:    cur_power = val[POWER_W-1:0];
			REG_EXPONENT: cur_expo = val[EXPO_W-1:0];
			REG_BASELINE: cur_base = val[BASE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_sample(input logic [RM_W-1:0] rm, input logic [RS_W-1:0] rs);
		int n;
		if (src_idle_on && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 16);
			sample.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		sample.rssi_master <= rm;
		sample.rssi_slave <= rs;
		sample.valid <= 1'b1;
		@(posedge clk);
		while (!sample.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain;
		sample.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	task automatic random_samples(input int count);
		logic [RM_W-1:0] rm;
		logic [RS_W-1:0] rs;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 3))
				0: begin
					rm = RM_W'($urandom);
					rs = RS_W'($urandom);
				end
				default: begin
					rm = 12'($signed(cur_power) + $signed(12'($urandom_range(0, 800))) - 200);
					rs = 8'(($signed(cur_power) >>> 4) + $urandom_range(0, 50) - 12);
				end
			endcase
			if ($urandom_range(0, 30) == 0)
				rm = 0;
			if ($urandom_range(0, 30) == 0)
				rs = 0;
			send_sample(rm, rs);
		end
	endtask

	initial begin
		sample.valid = 1'b0;
		sample.rssi_master = '0;
		sample.rssi_slave = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_POWER;
		cfg.data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, zero rssi, on baseline, saturation
		send_sample(12'h000, 8'h00);
		send_sample(12'h800, 8'h80);
		send_sample(12'h7FF, 8'h7F);
		send_sample(12'hB60, 8'hB6);
		send_sample(12'hFFF, 8'hFF);
		send_sample(12'h001, 8'h01);
		send_sample(12'hAAA, 8'h55);
		send_sample(12'h555, 8'hAA);
		send_sample(12'hB00, 8'h00);
		send_sample(12'h000, 8'hB0);
		send_sample(12'hC00, 8'hC0);
		drain();
		write_register(REG_EXPONENT, 16'd0);
		write_register(REG_BASELINE, 16'd0);
		send_sample(12'h800, 8'h80);
		send_sample(12'hB50, 8'hB5);
		send_sample(12'h7FF, 8'h7F);
		drain();
		write_register(REG_EXPONENT, 16'hFFFF);
		write_register(REG_BASELINE, 16'hFFFF);
		write_register(REG_POWER, 16'h0800);
		send_sample(12'h800, 8'h80);
		send_sample(12'h7FF, 8'h7F);
		send_sample(12'h001, 8'hFF);
		drain();
		write_register(REG_POWER, 16'h0000);
		write_register(REG_EXPONENT, 16'd1);
		write_register(REG_BASELINE, 16'd1);
		send_sample(12'h010, 8'h01);
		send_sample(12'hFF0, 8'hFF);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_register(REG_POWER, 16'($urandom_range(0, 2048) * -1));
			write_register(REG_EXPONENT, 16'($urandom_range(1, 4095)));
			write_register(REG_BASELINE, 16'($urandom_range(1, 65535)));
			if (ph == 7) begin
				src_idle_on = 1'b0;
				snk_idle_on = 1'b0;
			end
			random_samples(250);
			drain();
		end
		write_register(REG_POWER, 16'(-1184));
		write_register(REG_EXPONENT, 16'd768);
		write_register(REG_BASELINE, 16'd2000);
		random_samples(50);
		drain();

		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
